// ===== rtl/jsu_pkg.sv =====
// Package for the JSON string unescape block: beat types, decoder phases,
// the per-byte result record and UTF-8 / hex helper functions. No dependencies.
`default_nettype none
package jsu_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned MaxRes = 6;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChU     = 8'h75;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_NORMAL     = 4'd1,
    PH_ESC        = 4'd2,
    PH_HEX        = 4'd3,
    PH_HI_WAIT_BS = 4'd4,
    PH_HI_WAIT_U  = 4'd5,
    PH_HI_HEX     = 4'd6,
    PH_DONE       = 4'd7,
    PH_ERROR      = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2,
    ST_IGN  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    status_e    status;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } utf8_t;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [2:0]             cnt;
    status_e                status;
  } rec_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic utf8_t enc_cp(logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.b[0] = cp[7:0];
      r.n    = 3'd1;
    end else if (cp < 21'h800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.n    = 3'd2;
    end else if (cp < 21'h10000) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.n    = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.n    = 3'd4;
    end
    return r;
  endfunction

  function automatic utf8_t lit(logic [7:0] b);
    utf8_t r;
    r      = '0;
    r.b[0] = b;
    r.n    = 3'd1;
    return r;
  endfunction

  function automatic hex_t hex_val(logic [7:0] b);
    hex_t r;
    r = '0;
    if (b inside {[8'h30:8'h39]}) begin
      r.ok  = 1'b1;
      r.val = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r.ok  = 1'b1;
      r.val = b[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic logic [7:0] esc_map(logic [7:0] b);
    logic [7:0] o;
    case (b)
      8'h62:   o = 8'h08;
      8'h66:   o = 8'h0C;
      8'h6E:   o = 8'h0A;
      8'h72:   o = 8'h0D;
      8'h74:   o = 8'h09;
      default: o = b;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/json_string_unescape_utf8_top.sv =====
// JSON string unescape to UTF-8, top level: front decoder, record queue, back serializer.
// Each byte's result record is registered in the record queue before the back end offers it.
// Throughput: 1 input beat per cycle while the record queue is not full; a byte releasing k results
// takes max(k, 1) output beats from the back end (k up to 6); the 4-entry queue absorbs bursts.
// Reset: asynchronous active low, decoder to idle, queue empty.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
`default_nettype none
module json_string_unescape_utf8_top import jsu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_beat_t in_beat_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_beat_t     out_beat_o
);

  rec_t rec, head;
  logic full, empty, pop, take;

  assign in_ready_o = !full;
  assign take       = in_valid_i && !full;

  jsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .beat_i (in_beat_i),
    .rec_o  (rec)
  );

  jsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .rec_i   (rec),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
`default_nettype wire

// ===== rtl/jsu_front.sv =====
// Front end: escape / surrogate state machine, one input beat per cycle while take_i is high,
// turns each byte into a result record. Depends on jsu_pkg.
`default_nettype none
module jsu_front import jsu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     take_i,
  input  wire in_beat_t beat_i,
  output rec_t          rec_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  dc_q, dc_d;
  logic [9:0]  pend_q, pend_d;

  utf8_t       seq_a, seq_b;
  logic        err, ign;
  hex_t        hv;
  logic [15:0] acc_new;
  logic [20:0] high_cp;
  logic [7:0]  b;

  assign b       = beat_i.in_byte;
  assign hv      = hex_val(b);
  assign acc_new = {acc_q[11:0], hv.val};
  assign high_cp = {5'd0, 6'b110110, pend_q};

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    dc_d    = dc_q;
    pend_d  = pend_q;
    seq_a   = '0;
    seq_b   = '0;
    err     = 1'b0;
    ign     = 1'b0;
    if (beat_i.first) begin
      acc_d  = '0;
      dc_d   = '0;
      pend_d = '0;
      if (b == ChQuote) phase_d = PH_NORMAL;
      else err = 1'b1;
    end else begin
      case (phase_q)
        PH_NORMAL: begin
          if (b == ChQuote) phase_d = PH_DONE;
          else if (b == ChBsl) phase_d = PH_ESC;
          else seq_a = lit(b);
        end
        PH_ESC: begin
          if (b == ChU) begin
            acc_d   = '0;
            dc_d    = '0;
            phase_d = PH_HEX;
          end else begin
            seq_a   = lit(esc_map(b));
            phase_d = PH_NORMAL;
          end
        end
        PH_HEX: begin
          if (!hv.ok) err = 1'b1;
          else begin
            acc_d = acc_new;
            dc_d  = dc_q + 2'd1;
            if (dc_q == 2'd3) begin
              if (acc_new[15:10] == 6'b110110) begin
                pend_d  = acc_new[9:0];
                phase_d = PH_HI_WAIT_BS;
              end else begin
                seq_a   = enc_cp({5'd0, acc_new});
                phase_d = PH_NORMAL;
              end
            end
          end
        end
        PH_HI_WAIT_BS: begin
          if (b == ChBsl) phase_d = PH_HI_WAIT_U;
          else begin
            seq_a   = enc_cp(high_cp);
            phase_d = PH_NORMAL;
            if (b == ChQuote) phase_d = PH_DONE;
            else seq_b = lit(b);
          end
        end
        PH_HI_WAIT_U: begin
          if (b == ChU) begin
            acc_d   = '0;
            dc_d    = '0;
            phase_d = PH_HI_HEX;
          end else begin
            seq_a   = enc_cp(high_cp);
            seq_b   = lit(esc_map(b));
            phase_d = PH_NORMAL;
          end
        end
        PH_HI_HEX: begin
          if (!hv.ok) err = 1'b1;
          else begin
            acc_d = acc_new;
            dc_d  = dc_q + 2'd1;
            if (dc_q == 2'd3) begin
              if (acc_new[15:10] == 6'b110111) begin
                seq_a   = enc_cp(21'h10000 + {1'b0, pend_q, acc_new[9:0]});
                phase_d = PH_NORMAL;
              end else begin
                seq_a = enc_cp(high_cp);
                if (acc_new[15:10] == 6'b110110) begin
                  pend_d  = acc_new[9:0];
                  phase_d = PH_HI_WAIT_BS;
                end else begin
                  seq_b   = enc_cp({5'd0, acc_new});
                  phase_d = PH_NORMAL;
                end
              end
            end
          end
        end
        default: ign = 1'b1;
      endcase
    end
    if (!ign && !err && phase_d != PH_DONE && beat_i.end_of_text) err = 1'b1;
    if (err) phase_d = PH_ERROR;
  end

  always_comb begin
    logic [2:0] j;
    rec_o.bytes = '0;
    for (int i = 0; i < MaxRes; i++) begin
      j = 3'(i) - seq_a.n;
      if (3'(i) < seq_a.n) rec_o.bytes[i] = seq_a.b[i[1:0]];
      else if (j < 3'd4) rec_o.bytes[i] = seq_b.b[j[1:0]];
    end
    rec_o.cnt = seq_a.n + seq_b.n;
    if (ign) rec_o.status = ST_IGN;
    else if (err) rec_o.status = ST_ERR;
    else if (phase_d == PH_DONE) rec_o.status = ST_DONE;
    else rec_o.status = ST_RUN;
    if (err || ign) rec_o.cnt = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      dc_q    <= '0;
      pend_q  <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dc_q    <= dc_d;
      pend_q  <= pend_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jsu_queue.sv =====
// Short record queue between front and back end.
// Depends on jsu_pkg.
`default_nettype none
module jsu_queue import jsu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire rec_t rec_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      empty_o,
  output rec_t      head_o
);

  rec_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jsu_back.sv =====
// Back end: walks the head record and sends one result beat per cycle while the output is ready.
// Depends on jsu_pkg.
`default_nettype none
module jsu_back import jsu_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic empty_i,
  input  wire rec_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_beat_t out_beat_o
);

  logic [2:0] idx_q;
  logic [2:0] n_res;
  logic       is_last;

  assign n_res   = (head_i.cnt == '0) ? 3'd1 : head_i.cnt;
  assign is_last = (idx_q == n_res - 3'd1);

  assign out_valid_o         = !empty_i;
  assign out_beat_o.has_byte = (head_i.cnt != '0);
  assign out_beat_o.out_byte = (head_i.cnt != '0) ? head_i.bytes[idx_q] : 8'h00;
  assign out_beat_o.status   = head_i.status;
  assign out_beat_o.last     = is_last;
  assign pop_o               = out_valid_o && out_ready_i && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jsu_checker.sv =====
// Port-level checks for the JSON unescape top level, bound to it below.
// Depends on jsu_pkg.
`default_nettype none
module jsu_checker import jsu_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_beat_t out_beat_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_beat_o))
    else $error("output beat dropped or changed while stalled");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_beat_o.last |=>
      out_valid_o && out_beat_o.status == $past(out_beat_o.status))
    else $error("multi-beat result broken or status changed");

  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.has_byte |-> out_beat_o.last && out_beat_o.out_byte == 8'h00)
    else $error("byteless beat not single or not zero");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with nothing queued");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);
`default_nettype wire

// ===== tb/sv/json_string_unescape_utf8_top_tb.sv =====
// Self-checking bench for json_string_unescape_utf8_top: streams JSON string bytes,
// predicts the UTF-8 output in-bench and checks every output beat.
// Depends on jsu_pkg and json_string_unescape_utf8_top.
`timescale 1ns / 1ps

module json_string_unescape_utf8_top_tb;
  import jsu_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TextItems  = 340;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_beat_o;

  json_string_unescape_utf8_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_beat_t    text_q[$];
  out_beat_t   utf8_due[$];
  logic [7:0]  utf8_rel[$];
  out_beat_t   want_beat;
  int unsigned fails = 0;
  int unsigned cycles = 0;
  bit          in_took = 1'b0;
  bit          out_took = 1'b0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_wait = 0;

  // decoder shadow state
  phase_e      dec_phase = PH_IDLE;
  logic [15:0] hex_acc = '0;
  logic [1:0]  dig_cnt = '0;
  logic [9:0]  held_high = '0;
  bit          dec_err;

  function automatic int digit_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void rel_add(logic [7:0] c);
    utf8_rel.insert(utf8_rel.size(), c);
  endfunction

  function automatic void push_cp(logic [20:0] cp);
    if (cp < 21'h80) begin
      rel_add(cp[7:0]);
    end else if (cp < 21'h800) begin
      rel_add({3'b110, cp[10:6]});
      rel_add({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      rel_add({4'b1110, cp[15:12]});
      rel_add({2'b10, cp[11:6]});
      rel_add({2'b10, cp[5:0]});
    end else begin
      rel_add({5'b11110, cp[20:18]});
      rel_add({2'b10, cp[17:12]});
      rel_add({2'b10, cp[11:6]});
      rel_add({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void push_held_high();
    push_cp(21'hD800 + {11'd0, held_high});
  endfunction

  function automatic void accept_value(logic [15:0] v);
    if (v >= 16'hD800 && v <= 16'hDBFF) begin
      held_high = v[9:0];
      dec_phase = PH_HI_WAIT_BS;
    end else begin
      push_cp({5'd0, v});
      dec_phase = PH_NORMAL;
    end
  endfunction

  function automatic void step_plain(logic [7:0] c);
    if (c == ChQuote) dec_phase = PH_DONE;
    else if (c == ChBsl) dec_phase = PH_ESC;
    else rel_add(c);
  endfunction

  function automatic void step_escape(logic [7:0] c);
    logic [7:0] o;
    o = c;
    if (c == ChU) begin
      hex_acc = '0;
      dig_cnt = '0;
      dec_phase = PH_HEX;
      return;
    end
    case (c)
      "b":     o = 8'h08;
      "f":     o = 8'h0C;
      "n":     o = 8'h0A;
      "r":     o = 8'h0D;
      "t":     o = 8'h09;
      default: o = c;
    endcase
    rel_add(o);
    dec_phase = PH_NORMAL;
  endfunction

  // true once the fourth digit is in
  function automatic bit shift_digit(logic [7:0] c);
    int d;
    d = digit_of(c);
    if (d < 0) begin
      dec_err = 1'b1;
      return 1'b0;
    end
    hex_acc = {hex_acc[11:0], d[3:0]};
    if (dig_cnt == 2'd3) begin
      dig_cnt = '0;
      return 1'b1;
    end
    dig_cnt++;
    return 1'b0;
  endfunction

  function automatic void unescape_byte(in_beat_t ib);
    status_e    st;
    logic [7:0] c;
    out_beat_t  ob;
    st = ST_RUN;
    c = ib.in_byte;
    utf8_rel.delete();
    dec_err = 1'b0;
    if (ib.first) begin
      hex_acc = '0;
      dig_cnt = '0;
      held_high = '0;
      if (c == ChQuote) dec_phase = PH_NORMAL;
      else dec_err = 1'b1;
    end else begin
      case (dec_phase)
        PH_NORMAL: step_plain(c);
        PH_ESC:    step_escape(c);
        PH_HEX: begin
          if (shift_digit(c)) accept_value(hex_acc);
        end
        PH_HI_WAIT_BS: begin
          if (c == ChBsl) begin
            dec_phase = PH_HI_WAIT_U;
          end else begin
            push_held_high();
            dec_phase = PH_NORMAL;
            step_plain(c);
          end
        end
        PH_HI_WAIT_U: begin
          if (c == ChU) begin
            hex_acc = '0;
            dig_cnt = '0;
            dec_phase = PH_HI_HEX;
          end else begin
            push_held_high();
            step_escape(c);
          end
        end
        PH_HI_HEX: begin
          if (shift_digit(c)) begin
            if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
              push_cp(21'h10000 + {1'b0, held_high, hex_acc[9:0]});
              dec_phase = PH_NORMAL;
            end else begin
              push_held_high();
              accept_value(hex_acc);
            end
          end
        end
        default: st = ST_IGN;
      endcase
    end
    if (st != ST_IGN) begin
      if (!dec_err) begin
        if (dec_phase == PH_DONE) st = ST_DONE;
        else if (ib.end_of_text) dec_err = 1'b1;
      end
      if (dec_err) begin
        dec_phase = PH_ERROR;
        utf8_rel.delete();
        st = ST_ERR;
      end
    end
    ob.status = st;
    if (utf8_rel.size() == 0) begin
      ob.out_byte = 8'h00;
      ob.has_byte = 1'b0;
      ob.last     = 1'b1;
      utf8_due.insert(utf8_due.size(), ob);
    end else begin
      foreach (utf8_rel[i]) begin
        ob.out_byte = utf8_rel[i];
        ob.has_byte = 1'b1;
        ob.last     = (i == utf8_rel.size() - 1);
        utf8_due.insert(utf8_due.size(), ob);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // ---------------- stimulus builders
  function automatic void put(logic [7:0] c, bit f = 1'b0, bit e = 1'b0);
    in_beat_t ib;
    ib.in_byte     = c;
    ib.first       = f;
    ib.end_of_text = e;
    text_q.insert(text_q.size(), ib);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == ChQuote || c == ChBsl);
    return c;
  endfunction

  function automatic logic [7:0] bad_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (digit_of(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + {4'd0, v};
  endfunction

  function automatic void put_u(logic [15:0] v);
    put(ChBsl);
    put(ChU);
    for (int i = 3; i >= 0; i--) put(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void put_bad_u();
    int good;
    good = $urandom_range(0, 3);
    put(ChBsl);
    put(ChU);
    repeat (good) put(hex_char(4'($urandom_range(0, 15))));
    put(bad_digit());
  endfunction

  function automatic logic [15:0] pick_cp();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 16'h7F));
      1:       return 16'($urandom_range(16'h80, 16'h7FF));
      2:       return 16'($urandom_range(16'h800, 16'hFFFF));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [7:0] esc_letter();
    logic [7:0] c;
    case ($urandom_range(0, 8))
      0:       c = ChQuote;
      1:       c = ChBsl;
      2:       c = "/";
      3:       c = "b";
      4:       c = "f";
      5:       c = "n";
      6:       c = "r";
      7:       c = "t";
      default: do c = 8'($urandom_range(0, 255)); while (c == ChU);
    endcase
    return c;
  endfunction

  function automatic void put_surrogate_case();
    logic [15:0] v;
    put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
    case ($urandom_range(0, 6))
      0, 1: put_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
      2:    put(plain_byte());
      3: begin
        put(ChBsl);
        put(esc_letter());
      end
      4: begin
        do v = pick_cp(); while (v >= 16'hDC00 && v <= 16'hDFFF);
        put_u(v);
      end
      5:    put_bad_u();
      default: ;
    endcase
  endfunction

  function automatic void put_token();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5: put(plain_byte());
      6, 7, 8: begin
        put(ChBsl);
        put(esc_letter());
      end
      9, 10:     put_u(pick_cp());
      11, 12, 13: put_surrogate_case();
      14:        put_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
      default: begin
        if ($urandom_range(0, 3) == 0) put_bad_u();
        else put(plain_byte());
      end
    endcase
  endfunction

  function automatic void put_string();
    put(ChQuote, 1'b1, 1'b0);
    repeat ($urandom_range(0, 8)) put_token();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: put(ChQuote, 1'b0, 1'($urandom_range(0, 1)));
      6: begin
        put(ChQuote);
        repeat ($urandom_range(1, 3))
          put(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
      7: put(plain_byte(), 1'b0, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic void put_noise();
    repeat ($urandom_range(1, 4))
      put(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // ---------------- driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      if (!in_valid_i || in_took) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (text_q.size() != 0) begin
          in_beat_i  <= text_q.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
          in_gap = draw_wait(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_took) begin
        if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
        out_wait = draw_wait(out_calm);
      end
      if (out_wait != 0) begin
        out_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------- monitor
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout, %0d beats still due", $time, utf8_due.size());
      $display("Regression FAIL");
      $finish;
    end
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) unescape_byte(in_beat_i);
      if (out_valid_o && out_ready_i) begin
        if (utf8_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat, expected none actual %p", $time, out_beat_o);
        end else begin
          want_beat = utf8_due.pop_front();
          check_field("out_byte", want_beat.out_byte, out_beat_o.out_byte);
          check_field("has_byte", {7'd0, want_beat.has_byte}, {7'd0, out_beat_o.has_byte});
          check_field("status", {6'd0, want_beat.status}, {6'd0, out_beat_o.status});
          check_field("last", {7'd0, want_beat.last}, {7'd0, out_beat_o.last});
        end
      end
    end
    in_took  <= rst_ni && in_valid_i && in_ready_o;
    out_took <= rst_ni && out_valid_o && out_ready_i;
  end

  initial begin
    // idle ignore, missing quote, ignore after error
    put(8'h00, 1'b0, 1'b1);
    put(8'hFF, 1'b1, 1'b0);
    put(ChQuote, 1'b0, 1'b0);
    // byte extremes, max surrogate pair, NUL escape, close with end of text
    put(ChQuote, 1'b1);
    put(8'h00);
    put(8'hFF);
    put(ChBsl); put(ChU); put("D"); put("b"); put("F"); put("f");
    put(ChBsl); put(ChU); put("d"); put("F"); put("F"); put("F");
    put_u(16'h0000);
    put(ChQuote, 1'b0, 1'b1);
    // restart mid-string, then early end
    put(ChQuote, 1'b1);
    put("a");
    put(ChQuote, 1'b1);
    put("b", 1'b0, 1'b1);

    while (text_q.size() < TextItems) begin
      if ($urandom_range(0, 6) == 0) put_noise();
      else put_string();
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || in_valid_i || utf8_due.size() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fails == 0 && utf8_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
